### hw/rtl/swcb_pkg.sv
// shared types, constants and slot decode for the stopwatch clock bank
package swcb_pkg;

  localparam int unsigned USER_SLOTS   = 8;
  localparam int unsigned SYSTEM_SLOTS = 3;
  localparam int unsigned NUM_SLOTS    = SYSTEM_SLOTS + USER_SLOTS;
  localparam int unsigned SLOT_W       = $clog2(NUM_SLOTS);

  localparam logic [6:0]  USER_BASE     = 7'd100;
  localparam logic [31:0] WRAP_HIGH_MIN = 32'hF000_0001;
  localparam logic [31:0] WRAP_LOW_MAX  = 32'h1000_0000;

  // round(2^48 / ticks per second)
  localparam int unsigned TICK_SCALE_W = 23;
  localparam logic [TICK_SCALE_W-1:0] TICK_SCALE = 23'd6152199;

  localparam int unsigned PROD_W = 32 + TICK_SCALE_W;
  localparam int unsigned Q_W    = PROD_W + 2;
  localparam int unsigned OUT_W  = 48;

  localparam logic [Q_W-1:0] SAT_POS_Q = {{(Q_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic [Q_W-1:0] SAT_NEG_Q = {{(Q_W-OUT_W){1'b0}}, 1'b1, {(OUT_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ACT_INIT   = 2'd0,
    ACT_UPDATE = 2'd1,
    ACT_RESET  = 2'd2,
    ACT_QUERY  = 2'd3
  } action_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] idx;
  } slot_sel_t;

  typedef struct packed {
    logic vld;
    logic clock_valid;
  } res_ctl_t;

  function automatic slot_sel_t slot_decode(input logic [6:0] id);
    slot_sel_t  s;
    logic [6:0] ofs;
    s.hit = 1'b0;
    s.idx = '0;
    ofs   = id - USER_BASE;
    if (id >= USER_BASE) begin
      if (ofs < 7'(USER_SLOTS)) begin
        s.hit = 1'b1;
        s.idx = SLOT_W'(SYSTEM_SLOTS) + SLOT_W'(ofs);
      end
    end else if (id < 7'(SYSTEM_SLOTS)) begin
      s.hit = 1'b1;
      s.idx = SLOT_W'(id);
    end
    return s;
  endfunction

endpackage

### hw/rtl/swcb_state.sv
// input register, extended counter, snapshot slots and tick difference
module swcb_state (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [1:0]               in_action,
  input  logic [6:0]               in_clock_id,
  input  logic [31:0]              in_counter_now,
  output swcb_pkg::res_ctl_t       ctl_o,
  output logic [63:0]              diff_o
);

  logic                        in_vld_r;
  swcb_pkg::action_t           in_action_r;
  logic [6:0]                  in_id_r;
  logic [31:0]                 in_now_r;

  logic [31:0]                 last_r, last_nxt;
  logic [31:0]                 wrap_r, wrap_nxt;
  logic [63:0]                 snap_r [swcb_pkg::NUM_SLOTS];

  swcb_pkg::res_ctl_t          ctl_r, ctl_nxt;
  logic [63:0]                 diff_r, diff_nxt;

  swcb_pkg::slot_sel_t         sel;
  logic                        wrap_hit;
  logic [31:0]                 wrap_inc;
  logic [63:0]                 ext_new;
  logic                        snap_we;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start;
    end
    in_action_r <= swcb_pkg::action_t'(in_action);
    in_id_r     <= in_clock_id;
    in_now_r    <= in_counter_now;
  end

  always_comb begin
    sel      = swcb_pkg::slot_decode(in_id_r);
    wrap_hit = (last_r >= swcb_pkg::WRAP_HIGH_MIN) && (in_now_r < swcb_pkg::WRAP_LOW_MAX);
    wrap_inc = wrap_r + {31'd0, wrap_hit};
    ext_new  = {wrap_inc, in_now_r};
    last_nxt = last_r;
    wrap_nxt = wrap_r;
    snap_we  = 1'b0;
    ctl_nxt  = '0;
    diff_nxt = ext_new - snap_r[sel.idx];
    if (in_vld_r) begin
      unique case (in_action_r)
        swcb_pkg::ACT_INIT: begin
          last_nxt = in_now_r;
          wrap_nxt = '0;
        end
        swcb_pkg::ACT_UPDATE: begin
          last_nxt = in_now_r;
          wrap_nxt = wrap_inc;
        end
        swcb_pkg::ACT_RESET: begin
          last_nxt = in_now_r;
          wrap_nxt = wrap_inc;
          snap_we  = sel.hit;
        end
        swcb_pkg::ACT_QUERY: begin
          ctl_nxt.vld         = 1'b1;
          ctl_nxt.clock_valid = sel.hit;
          if (sel.hit) begin
            last_nxt = in_now_r;
            wrap_nxt = wrap_inc;
          end
        end
        default: begin
          last_nxt = last_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
      wrap_r <= '0;
      ctl_r  <= '0;
      for (int i = 0; i < int'(swcb_pkg::NUM_SLOTS); i++) begin
        snap_r[i] <= '0;
      end
    end else begin
      last_r <= last_nxt;
      wrap_r <= wrap_nxt;
      ctl_r  <= ctl_nxt;
      if (snap_we) begin
        snap_r[sel.idx] <= ext_new;
      end
    end
    diff_r <= diff_nxt;
  end

  assign ctl_o  = ctl_r;
  assign diff_o = diff_r;

endmodule

### hw/rtl/swcb_scale.sv
// pipelined tick-to-seconds scaling with rounding toward minus infinity and saturation
module swcb_scale (
  input  logic                         clk,
  input  logic                         rst_n,
  input  swcb_pkg::res_ctl_t           ctl_i,
  input  logic [63:0]                  diff_i,
  output logic                         out_valid,
  output logic signed [swcb_pkg::OUT_W-1:0] out_elapsed_seconds,
  output logic                         out_clock_valid
);

  swcb_pkg::res_ctl_t                  ctl1_r, ctl2_r, ctl3_r;
  logic                                neg1_r, neg2_r, neg3_r;
  logic [63:0]                         mag1_r;
  logic [swcb_pkg::PROD_W-1:0]         lo2_r, hi2_r;
  logic [swcb_pkg::Q_W-1:0]            q3_r;
  logic                                frac3_r;

  logic                                out_valid_r;
  logic [swcb_pkg::OUT_W-1:0]          out_sec_r, out_sec_nxt;
  logic                                out_cv_r;

  logic [swcb_pkg::Q_W-1:0]            q_adj;

  // magnitude, two partial products, combine
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
    end else begin
      ctl1_r <= ctl_i;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
    end
    neg1_r  <= diff_i[63];
    mag1_r  <= diff_i[63] ? (64'd0 - diff_i) : diff_i;
    neg2_r  <= neg1_r;
    lo2_r   <= swcb_pkg::PROD_W'(mag1_r[31:0]) * swcb_pkg::PROD_W'(swcb_pkg::TICK_SCALE);
    hi2_r   <= swcb_pkg::PROD_W'(mag1_r[63:32]) * swcb_pkg::PROD_W'(swcb_pkg::TICK_SCALE);
    neg3_r  <= neg2_r;
    q3_r    <= swcb_pkg::Q_W'(hi2_r) + swcb_pkg::Q_W'(lo2_r[swcb_pkg::PROD_W-1:32]);
    frac3_r <= |lo2_r[31:0];
  end

  always_comb begin
    q_adj       = q3_r + {{(swcb_pkg::Q_W-1){1'b0}}, frac3_r};
    out_sec_nxt = '0;
    if (ctl3_r.clock_valid) begin
      if (!neg3_r) begin
        out_sec_nxt = (q3_r > swcb_pkg::SAT_POS_Q) ? swcb_pkg::SAT_POS_Q[swcb_pkg::OUT_W-1:0]
                                                   : q3_r[swcb_pkg::OUT_W-1:0];
      end else if (q_adj > swcb_pkg::SAT_NEG_Q) begin
        out_sec_nxt = swcb_pkg::SAT_NEG_Q[swcb_pkg::OUT_W-1:0];
      end else begin
        out_sec_nxt = swcb_pkg::OUT_W'(0) - q_adj[swcb_pkg::OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl3_r.vld;
    end
    out_sec_r <= out_sec_nxt;
    out_cv_r  <= ctl3_r.clock_valid;
  end

  assign out_valid           = out_valid_r;
  assign out_elapsed_seconds = signed'(out_sec_r);
  assign out_clock_valid     = out_cv_r;

endmodule

### hw/rtl/stopwatch_clock_bank.sv
// top level of the stopwatch clock bank
// Command channel: a transfer happens at a rising edge with start high and
// busy low; busy is low except while reset is held, so one command can be
// given every cycle.
// Commands: init, update sample, reset slot to now, query elapsed seconds.
// Each command carries a slot id and the current 32-bit counter sample.
// The counter sample, wrap count and snapshot slots are updated from the
// input register in the cycle after the transfer, in command order, so
// back-to-back commands see the state left by the one before.
// Only a query gives a result: out_valid is high for exactly one cycle,
// after the command passes the input, state and scaling registers and the
// output register, with the elapsed seconds (signed Q31.16, saturated) and
// out_clock_valid. The scaling pipeline has the steps magnitude, two 32 by
// 23 partial products, combine, then round and saturate. Throughput is one
// item per cycle, and results leave in command order.
// The receiver takes every result in the cycle it is shown.
// Reset (synchronous, active low) clears the sample, the wrap count, all
// snapshot slots and the pipeline valid bits; no result is in flight after it.
module stopwatch_clock_bank (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [1:0]                             in_action,
  input  logic [6:0]                             in_clock_id,
  input  logic [31:0]                            in_counter_now,
  output logic                                   out_valid,
  output logic signed [swcb_pkg::OUT_W-1:0]      out_elapsed_seconds,
  output logic                                   out_clock_valid
);

  swcb_pkg::res_ctl_t ctl;
  logic [63:0]        diff;

  assign busy = ~rst_n;

  swcb_state u_state (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .in_action      (in_action),
    .in_clock_id    (in_clock_id),
    .in_counter_now (in_counter_now),
    .ctl_o          (ctl),
    .diff_o         (diff)
  );

  swcb_scale u_scale (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ctl_i               (ctl),
    .diff_i              (diff),
    .out_valid           (out_valid),
    .out_elapsed_seconds (out_elapsed_seconds),
    .out_clock_valid     (out_clock_valid)
  );

endmodule
